// ===== src/four_channel_frame_crc16_defines.svh =====
// Assertion macros shared by the frame CRC block
`ifndef FOUR_CHANNEL_FRAME_CRC16_DEFINES_SVH
`define FOUR_CHANNEL_FRAME_CRC16_DEFINES_SVH

// check cons in the same cycle as ante
`define FCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame crc check failed");

// check cons in the cycle after ante
`define FCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame crc check failed");

`endif

// ===== src/fcc_pkg.sv =====
// Types, constants and CRC step function for the four-channel frame CRC block
`timescale 1ns / 1ps

package fcc_pkg;

    localparam int NUM_CHAN      = 4;
    localparam int PAYLOAD_LEN   = 8;
    localparam int BEAT_W        = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [BEAT_W-1:0] PAYLOAD_BEATS = 4'd8;
    localparam logic [BEAT_W-1:0] CRC_LO_BEAT   = 4'd8;
    localparam logic [BEAT_W-1:0] LAST_BEAT     = 4'd9;

    typedef logic [BEAT_W-1:0] beat_idx_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic init;
        logic update;
    } crc_ctrl_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ===== src/fcc_if.sv =====
// Sample and frame byte channel interfaces
`timescale 1ns / 1ps

interface fcc_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] chan0;
    logic signed [15:0] chan1;
    logic signed [15:0] chan2;
    logic signed [15:0] chan3;

    modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                    input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2, input chan3,
                    output ready);
endinterface

interface fcc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== src/fcc_byte_cell.sv =====
// One byte cell of the frame shift line
`timescale 1ns / 1ps

module fcc_byte_cell (
    input  logic                clk,
    input  fcc_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          load_byte,
    input  logic [7:0]          shift_in,
    output logic [7:0]          byte_q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.load)
            byte_next = load_byte;
        else if (ctrl.shift)
            byte_next = shift_in;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;

endmodule

// ===== src/fcc_crc_cell.sv =====
// Running CRC-16 cell fed by the head of the shift line
`timescale 1ns / 1ps

module fcc_crc_cell (
    input  logic               clk,
    input  fcc_pkg::crc_ctrl_t ctrl,
    input  logic [7:0]         data,
    output logic [15:0]        crc_q
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.init)
            crc_next = fcc_pkg::CRC_INIT;
        else if (ctrl.update)
            crc_next = fcc_pkg::crc16_byte(crc_reg, data);
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

    assign crc_q = crc_reg;

endmodule

// ===== src/four_channel_frame_crc16.sv =====
// Top level: four-channel sample framer with CRC-16 trailer
// A frame's first byte is offered once its staged sample beat has set the busy flag.
// Ten bytes per frame, one byte per cycle while frame.ready holds, on the single byte lane.
// A staging register takes the next sample beat while the current frame drains.
// Reset clears the staging flag, frame busy flag and beat index; data cells hold no reset.
`timescale 1ns / 1ps
`include "four_channel_frame_crc16_defines.svh"

module four_channel_frame_crc16 (
    input  logic        clk,
    input  logic        rst_n,
    fcc_sample_if.sink  sample,
    fcc_frame_if.source frame
);

    logic [15:0]          stage_reg [fcc_pkg::NUM_CHAN];
    logic                 stage_full_reg;
    logic                 stage_full_next;
    logic                 busy_reg;
    logic                 busy_next;
    fcc_pkg::beat_idx_t   idx_reg;
    fcc_pkg::beat_idx_t   idx_next;

    logic                 in_fire;
    logic                 out_fire;
    logic                 last_fire;
    logic                 start;
    logic                 in_payload;

    fcc_pkg::cell_ctrl_t  cell_ctrl;
    fcc_pkg::crc_ctrl_t   crc_ctrl;
    logic [7:0]           chain [fcc_pkg::PAYLOAD_LEN + 1];
    logic [7:0]           load_bytes [fcc_pkg::PAYLOAD_LEN];
    logic [15:0]          crc;

    assign sample.ready = !stage_full_reg;
    assign in_fire      = sample.valid && !stage_full_reg;
    assign out_fire     = frame.valid && frame.ready;
    assign last_fire    = out_fire && (idx_reg == fcc_pkg::LAST_BEAT);
    assign start        = stage_full_reg && (!busy_reg || last_fire);
    assign in_payload   = idx_reg < fcc_pkg::PAYLOAD_BEATS;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_reg[0] <= sample.chan0;
            stage_reg[1] <= sample.chan1;
            stage_reg[2] <= sample.chan2;
            stage_reg[3] <= sample.chan3;
        end
    end

    always_comb
    begin
        stage_full_next = stage_full_reg;
        if (in_fire)
            stage_full_next = 1'b1;
        else if (start)
            stage_full_next = 1'b0;

        busy_next = busy_reg;
        if (start)
            busy_next = 1'b1;
        else if (last_fire)
            busy_next = 1'b0;

        idx_next = idx_reg;
        if (start)
            idx_next = '0;
        else if (out_fire)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_full_reg <= 1'b0;
            busy_reg       <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            stage_full_reg <= stage_full_next;
            busy_reg       <= busy_next;
            idx_reg        <= idx_next;
        end
    end

    assign cell_ctrl.load  = start;
    assign cell_ctrl.shift = out_fire;
    assign crc_ctrl.init   = start;
    assign crc_ctrl.update = out_fire && in_payload;

    assign chain[fcc_pkg::PAYLOAD_LEN] = 8'h00;

    genvar gi;
    generate
        for (gi = 0; gi < fcc_pkg::PAYLOAD_LEN; gi++)
        begin : g_cell
            if (gi % 2 == 0)
            begin : g_lo
                assign load_bytes[gi] = stage_reg[gi / 2][7:0];
            end
            else
            begin : g_hi
                assign load_bytes[gi] = stage_reg[gi / 2][15:8];
            end

            fcc_byte_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .load_byte (load_bytes[gi]),
                .shift_in  (chain[gi + 1]),
                .byte_q    (chain[gi])
            );
        end
    endgenerate

    fcc_crc_cell u_crc (
        .clk   (clk),
        .ctrl  (crc_ctrl),
        .data  (chain[0]),
        .crc_q (crc)
    );

    always_comb
    begin
        if (in_payload)
            frame.frame_byte = chain[0];
        else if (idx_reg == fcc_pkg::CRC_LO_BEAT)
            frame.frame_byte = crc[7:0];
        else
            frame.frame_byte = crc[15:8];
    end

    assign frame.valid     = busy_reg;
    assign frame.frame_end = (idx_reg == fcc_pkg::LAST_BEAT);

    `FCC_ASSERT_NOW(a_idx_range, busy_reg, idx_reg <= fcc_pkg::LAST_BEAT)
    `FCC_ASSERT_NEXT(a_start_loads, start, busy_reg && !stage_full_reg && idx_reg == '0)
    `FCC_ASSERT_NEXT(a_crc_init, start, crc == fcc_pkg::CRC_INIT)
    `FCC_ASSERT_NEXT(a_last_idle, last_fire && !stage_full_reg, !busy_reg)

endmodule
